@@ hdl/ppp_pkg.sv @@
// shared types and constants for the pulse peak and pedestal block
`default_nettype none

package ppp_pkg;

    // fixed field and state widths
    localparam int IDX_W     = 8;
    localparam int PEAK_W    = 12;
    localparam int OUT_W     = 16;
    localparam int WCNT_W    = 9;
    localparam int SUM_W     = 20;
    localparam int SUMSQ_W   = 32;
    localparam int FRAC_BITS = 4;
    localparam int RAW_W     = 16;

    // variance scaling: 256 = 2^8 before the root
    localparam int SCALE_BITS = 8;
    localparam int PROD_W     = WCNT_W + SUMSQ_W;
    localparam int RAD_W      = ((PROD_W + SCALE_BITS + 1) / 2) * 2;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int DIV_W      = ROOT_W;
    localparam int STEP_W     = $clog2(ROOT_W);

    // configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PED_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PED_LAST  = 1'b1;
    localparam logic [IDX_W-1:0] PED_FIRST_RST = 8'd1;
    localparam logic [IDX_W-1:0] PED_LAST_RST  = 8'd100;

    typedef struct packed {
        logic sample_en;
        logic mult_en;
        logic root_load;
        logic div_load_mean;
        logic div_load_root;
        logic mean_save;
        logic out_load;
    } ppp_cmd_t;

    typedef struct packed {
        logic root_busy;
        logic div_busy;
    } ppp_status_t;

endpackage

`default_nettype wire

@@ hdl/pulse_peak_and_pedestal.sv @@
// Pulse peak finder with pedestal mean and rms for one digitizer channel.
//
// Input channel (in_valid / in_stall): one converter word per transfer, with
// last_sample marking the end of a record. Samples are taken one per cycle
// while a record is running. Output channel (out_valid / out_stall): one
// transfer per record carrying the peak index and value, the pedestal mean
// and rms (4 fraction bits) and the empty-window flag.
// After the last sample of a record is taken, in_stall stays high while the
// record's products, the square root (two radicand bits a cycle) and two
// serial divisions by the window count run; the mean division runs
// alongside the root and the rms division follows them. The result register
// then loads and out_valid rises.
// If the previous result is still held because the receiver stalls, the new
// one waits in the sequencer and in_stall stays high; otherwise the next
// record starts while the result waits to be taken.
// Reset clears the record state and loads ped_first = 1, ped_last = 100.
// The window registers are written through cfg_wr_en / cfg_index / cfg_data
// and should only change between records.
`default_nettype none

module pulse_peak_and_pedestal
    import ppp_pkg::*;
#(
    parameter int MAX_SAMPLES = 256,
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [RAW_W-1:0]      raw_sample,
    input  wire logic                  last_sample,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [IDX_W-1:0]           peak_index,
    output logic [PEAK_W-1:0]          peak_value,
    output logic [OUT_W-1:0]           ped_mean_q4,
    output logic [OUT_W-1:0]           ped_rms_q4,
    output logic                       ped_empty
);

    ppp_cmd_t    cmd;
    ppp_status_t status;

    ppp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_sample (last_sample),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cmd         (cmd)
    );

    ppp_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .raw_sample  (raw_sample),
        .peak_index  (peak_index),
        .peak_value  (peak_value),
        .ped_mean_q4 (ped_mean_q4),
        .ped_rms_q4  (ped_rms_q4),
        .ped_empty   (ped_empty)
    );

endmodule

`default_nettype wire

@@ hdl/ppp_isqrt.sv @@
// iterative integer square root, two radicand bits per cycle
`default_nettype none

module ppp_isqrt
    import ppp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   busy,
    output logic [ROOT_W-1:0]      root
);

    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                busy_reg;

    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic                fits;

    always_comb
    begin
        rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ hdl/ppp_divider.sv @@
// restoring divider by the window count, one quotient bit per cycle
`default_nettype none

module ppp_divider
    import ppp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  numer,
    input  wire logic [WCNT_W-1:0] denom,
    output logic                   busy,
    output logic [DIV_W-1:0]       quot
);

    logic [DIV_W-1:0]   q_reg;
    logic [WCNT_W-1:0]  rem_reg;
    logic [WCNT_W-1:0]  denom_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;

    logic [WCNT_W:0]    rem_sh;
    logic [WCNT_W:0]    rem_sub;
    logic               fits;

    always_comb
    begin
        rem_sh  = {rem_reg, q_reg[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, denom_reg};
        fits    = rem_sh >= {1'b0, denom_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // numerator shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg     <= numer;
            rem_reg   <= '0;
            denom_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[WCNT_W-1:0] : rem_sh[WCNT_W-1:0];
            q_reg   <= {q_reg[DIV_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

@@ hdl/ppp_datapath.sv @@
// sample front end, pedestal sums, per-record arithmetic and result register
`default_nettype none

module ppp_datapath
    import ppp_pkg::*;
#(
    parameter int MAX_SAMPLES = 256,
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ppp_cmd_t              cmd,
    output ppp_status_t                status,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [RAW_W-1:0]      raw_sample,
    output logic [IDX_W-1:0]           peak_index,
    output logic [PEAK_W-1:0]          peak_value,
    output logic [OUT_W-1:0]           ped_mean_q4,
    output logic [OUT_W-1:0]           ped_rms_q4,
    output logic                       ped_empty
);

    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int VAL_CMP_W = (SAMPLE_BITS > PEAK_W) ? SAMPLE_BITS : PEAK_W;
    localparam int SQ_W      = 2 * SAMPLE_BITS;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK = '1;

    logic [IDX_W-1:0]       ped_first_reg;
    logic [IDX_W-1:0]       ped_last_reg;
    logic [CNT_W-1:0]       sample_cnt_reg;
    logic [PEAK_W-1:0]      best_value_reg;
    logic [IDX_W-1:0]       best_index_reg;
    logic [WCNT_W-1:0]      win_cnt_reg;
    logic [SUM_W-1:0]       win_sum_reg;
    logic [SUMSQ_W-1:0]     win_sumsq_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic                   sq_pending_reg;
    logic [PROD_W-1:0]      prod_a_reg;
    logic [PROD_W-1:0]      prod_b_reg;
    logic [OUT_W-1:0]       mean_reg;

    logic [IDX_W-1:0]       peak_index_reg;
    logic [PEAK_W-1:0]      peak_value_reg;
    logic [OUT_W-1:0]       mean_out_reg;
    logic [OUT_W-1:0]       rms_out_reg;
    logic                   empty_reg;

    logic [SAMPLE_BITS-1:0] val;
    logic                   in_range;
    logic [IDX_CMP_W-1:0]   idx_ext;
    logic                   in_window;
    logic                   is_peak;
    logic [PROD_W-1:0]      diff;
    logic [RAD_W-1:0]       radicand;
    logic [DIV_W-1:0]       div_numer;
    logic                   win_empty;

    logic                   root_busy;
    logic                   div_busy;
    logic [ROOT_W-1:0]      root;
    logic [DIV_W-1:0]       quot;

    always_comb
    begin
        val       = SAMPLE_MASK - raw_sample[SAMPLE_BITS-1:0];
        in_range  = sample_cnt_reg != CNT_W'(MAX_SAMPLES);
        idx_ext   = IDX_CMP_W'(sample_cnt_reg);
        in_window = in_range && (idx_ext >= IDX_CMP_W'(ped_first_reg))
                    && (idx_ext <= IDX_CMP_W'(ped_last_reg));
        is_peak   = in_range && (VAL_CMP_W'(val) > VAL_CMP_W'(best_value_reg));
        diff      = (prod_a_reg > prod_b_reg) ? (prod_a_reg - prod_b_reg) : '0;
        radicand  = RAD_W'({diff, {SCALE_BITS{1'b0}}});
        div_numer = cmd.div_load_root ? DIV_W'(root)
                                      : DIV_W'({win_sum_reg, {FRAC_BITS{1'b0}}});
        win_empty = win_cnt_reg == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ped_first_reg <= PED_FIRST_RST;
            ped_last_reg  <= PED_LAST_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PED_FIRST: ped_first_reg <= cfg_data;
                REG_PED_LAST:  ped_last_reg  <= cfg_data;
                default:       ped_first_reg <= ped_first_reg;
            endcase
        end
    end

    // record state; cleared when the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_cnt_reg <= '0;
            best_value_reg <= '0;
            best_index_reg <= '0;
            win_cnt_reg    <= '0;
            win_sum_reg    <= '0;
            win_sumsq_reg  <= '0;
            sq_pending_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            sample_cnt_reg <= '0;
            best_value_reg <= '0;
            best_index_reg <= '0;
            win_cnt_reg    <= '0;
            win_sum_reg    <= '0;
            win_sumsq_reg  <= '0;
            sq_pending_reg <= 1'b0;
        end
        else
        begin
            sq_pending_reg <= cmd.sample_en && in_window;
            if (cmd.sample_en && in_range)
            begin
                sample_cnt_reg <= sample_cnt_reg + 1'b1;
                if (is_peak)
                begin
                    best_value_reg <= PEAK_W'(val);
                    best_index_reg <= IDX_W'(sample_cnt_reg);
                end
                if (in_window)
                begin
                    win_cnt_reg <= win_cnt_reg + 1'b1;
                    win_sum_reg <= win_sum_reg + SUM_W'(val);
                end
            end
            // square lands in the cycle after its sample
            if (sq_pending_reg)
            begin
                win_sumsq_reg <= win_sumsq_reg + SUMSQ_W'(sq_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sample_en)
        begin
            sq_reg <= SQ_W'(val) * SQ_W'(val);
        end
        if (cmd.mult_en)
        begin
            prod_a_reg <= PROD_W'(win_cnt_reg) * PROD_W'(win_sumsq_reg);
            prod_b_reg <= PROD_W'(win_sum_reg) * PROD_W'(win_sum_reg);
        end
        if (cmd.mean_save)
        begin
            mean_reg <= quot[OUT_W-1:0];
        end
        if (cmd.out_load)
        begin
            peak_index_reg <= best_index_reg;
            peak_value_reg <= best_value_reg;
            mean_out_reg   <= win_empty ? '0 : mean_reg;
            rms_out_reg    <= win_empty ? '0 : quot[OUT_W-1:0];
            empty_reg      <= win_empty;
        end
    end

    ppp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_load),
        .radicand (radicand),
        .busy     (root_busy),
        .root     (root)
    );

    ppp_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_load_mean || cmd.div_load_root),
        .numer (div_numer),
        .denom (win_cnt_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    always_comb
    begin
        status.root_busy = root_busy;
        status.div_busy  = div_busy;
    end

    assign peak_index  = peak_index_reg;
    assign peak_value  = peak_value_reg;
    assign ped_mean_q4 = mean_out_reg;
    assign ped_rms_q4  = rms_out_reg;
    assign ped_empty   = empty_reg;

endmodule

`default_nettype wire

@@ hdl/ppp_ctrl.sv @@
// record sequencer: sample intake, end-of-record arithmetic, result handshake
`default_nettype none

module ppp_ctrl
    import ppp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        last_sample,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire ppp_status_t status,
    output ppp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_RUN,
        S_DRAIN,
        S_MULT,
        S_START,
        S_ROOT,
        S_MEAN,
        S_DIVR,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_RUN:
            begin
                cmd.sample_en = in_valid;
                if (in_valid && last_sample)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_MULT;
            S_MULT:
            begin
                cmd.mult_en = 1'b1;
                state_next  = S_START;
            end
            S_START:
            begin
                cmd.root_load     = 1'b1;
                cmd.div_load_mean = 1'b1;
                state_next        = S_ROOT;
            end
            S_ROOT:
            begin
                if (!status.root_busy && !status.div_busy)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.mean_save     = 1'b1;
                cmd.div_load_root = 1'b1;
                state_next        = S_DIVR;
            end
            S_DIVR:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_RUN;
                end
            end
            default: state_next = S_RUN;
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_RUN;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hdl/ppp_checker.sv @@
// port-level checks for the pulse peak and pedestal block, bound to the top level
`default_nettype none

module ppp_checker
    import ppp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic                  last_sample,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [IDX_W-1:0]      peak_index,
    input  wire logic [PEAK_W-1:0]     peak_value,
    input  wire logic [OUT_W-1:0]      ped_mean_q4,
    input  wire logic [OUT_W-1:0]      ped_rms_q4,
    input  wire logic                  ped_empty
);

    // a held result must not change or vanish
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(peak_index)
            && $stable(peak_value) && $stable(ped_mean_q4) && $stable(ped_rms_q4)
            && $stable(ped_empty))
        else $error("stalled result changed");

    // end of record stops intake while the record is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_sample |=> in_stall)
        else $error("sample taken right after end of record");

    // empty window forces zero mean and rms
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ped_empty |-> ped_mean_q4 == '0 && ped_rms_q4 == '0)
        else $error("empty window with nonzero statistics");

    // no sample above zero leaves the peak index at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && peak_value == '0 |-> peak_index == '0)
        else $error("zero peak with nonzero index");

endmodule

bind pulse_peak_and_pedestal ppp_checker u_ppp_checker (.*);

`default_nettype wire

@@ tb/sv/pulse_record_checker.sv @@
// record summary predictor and result checker for the pulse peak and pedestal block
`timescale 1ns / 100ps

module pulse_record_checker
    import ppp_pkg::*;
#(
    parameter int RECORD_MAX = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [RAW_W-1:0]      raw_sample,
    input  wire logic                  last_sample,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [IDX_W-1:0]      peak_index,
    input  wire logic [PEAK_W-1:0]     peak_value,
    input  wire logic [OUT_W-1:0]      ped_mean_q4,
    input  wire logic [OUT_W-1:0]      ped_rms_q4,
    input  wire logic                  ped_empty,
    output int                         mismatches,
    output int                         waiting,
    output int                         results_seen
);

    typedef struct {
        logic [IDX_W-1:0]  index;
        logic [PEAK_W-1:0] value;
        logic [OUT_W-1:0]  mean;
        logic [OUT_W-1:0]  rms;
        logic              empty;
    } record_summary_t;

    record_summary_t summaries[$];

    // window registers as last written
    logic [IDX_W-1:0]   win_first;
    logic [IDX_W-1:0]   win_last;

    // running record state
    int                 rec_pos;
    logic [PEAK_W-1:0]  best_level;
    logic [IDX_W-1:0]   best_pos;
    logic [WCNT_W-1:0]  win_n;
    logic [SUM_W-1:0]   win_sum;
    logic [SUMSQ_W-1:0] win_sumsq;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void clear_record();
        rec_pos    = 0;
        best_level = '0;
        best_pos   = '0;
        win_n      = '0;
        win_sum    = '0;
        win_sumsq  = '0;
    endfunction

    function automatic void take_sample(logic [RAW_W-1:0] word, logic is_last);
        logic [PEAK_W-1:0] level;
        longint unsigned n, s, q, a, b, r;
        record_summary_t summary;
        if (rec_pos < RECORD_MAX)
        begin
            // digitizer pulses go negative, so invert
            level = {PEAK_W{1'b1}} - word[PEAK_W-1:0];
            if (level > best_level)
            begin
                best_level = level;
                best_pos   = IDX_W'(rec_pos);
            end
            if (rec_pos >= int'(win_first) && rec_pos <= int'(win_last))
            begin
                win_n     = win_n + 1'b1;
                win_sum   = win_sum + SUM_W'(level);
                win_sumsq = win_sumsq + SUMSQ_W'(level) * SUMSQ_W'(level);
            end
            rec_pos++;
        end
        if (is_last)
        begin
            summary.index = best_pos;
            summary.value = best_level;
            summary.mean  = '0;
            summary.rms   = '0;
            summary.empty = (win_n == 0);
            if (win_n != 0)
            begin
                n = win_n;
                s = win_sum;
                q = win_sumsq;
                a = n * q;
                b = s * s;
                summary.mean = OUT_W'((s * 16) / n);
                if (a > b)
                begin
                    r = int_root((a - b) * 256) / n;
                    summary.rms = OUT_W'(r);
                end
            end
            summaries.push_back(summary);
            clear_record();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        record_summary_t want;
        logic bad;
        if (!rst_n)
        begin
            win_first    <= PED_FIRST_RST;
            win_last     <= PED_LAST_RST;
            summaries.delete();
            clear_record();
            mismatches   <= 0;
            waiting      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PED_FIRST: win_first <= cfg_data;
                    REG_PED_LAST:  win_last  <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                take_sample(raw_sample, last_sample);
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (summaries.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing pending: idx %0d peak %0d mean %0d rms %0d empty %0d",
                                 $time, peak_index, peak_value, ped_mean_q4, ped_rms_q4, ped_empty);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = summaries.pop_front();
                    bad = 1'b0;
                    if (peak_index  !== want.index) bad = 1'b1;
                    if (peak_value  !== want.value) bad = 1'b1;
                    if (ped_mean_q4 !== want.mean)  bad = 1'b1;
                    if (ped_rms_q4  !== want.rms)   bad = 1'b1;
                    if (ped_empty   !== want.empty) bad = 1'b1;
                    if (bad)
                    begin
                        if (mismatches < 10)
                            $display("%0t: record %0d expected idx %0d peak %0d mean %0d rms %0d empty %0d, got idx %0d peak %0d mean %0d rms %0d empty %0d",
                                     $time, results_seen, want.index, want.value, want.mean,
                                     want.rms, want.empty, peak_index, peak_value, ped_mean_q4,
                                     ped_rms_q4, ped_empty);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            waiting <= summaries.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// stimulus, window setup and verdict for the pulse peak and pedestal block
`timescale 1ns / 100ps

module testbench
    import ppp_pkg::*;
();

    localparam int RECORD_MAX  = 256;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [RAW_W-1:0]      raw_sample;
    logic                  last_sample;
    logic                  out_valid;
    logic                  out_stall;
    logic [IDX_W-1:0]      peak_index;
    logic [PEAK_W-1:0]     peak_value;
    logic [OUT_W-1:0]      ped_mean_q4;
    logic [OUT_W-1:0]      ped_rms_q4;
    logic                  ped_empty;

    int mismatches;
    int waiting;
    int results_seen;

    int burst_left  = 0;
    int samples_in  = 0;
    int records_in  = 0;
    int windows_set = 0;
    int quiet       = 0;

    pulse_peak_and_pedestal #(
        .MAX_SAMPLES(RECORD_MAX),
        .SAMPLE_BITS(PEAK_W)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_sample  (raw_sample),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .peak_index  (peak_index),
        .peak_value  (peak_value),
        .ped_mean_q4 (ped_mean_q4),
        .ped_rms_q4  (ped_rms_q4),
        .ped_empty   (ped_empty)
    );

    pulse_record_checker #(
        .RECORD_MAX(RECORD_MAX)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_sample   (raw_sample),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .peak_index   (peak_index),
        .peak_value   (peak_value),
        .ped_mean_q4  (ped_mean_q4),
        .ped_rms_q4   (ped_rms_q4),
        .ped_empty    (ped_empty),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d summaries still pending", quiet, waiting);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls in stretches of different density
    initial
    begin : receiver
        int mode;
        int span;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 80);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 3) == 0);
                    2:       out_stall = ($urandom_range(0, 1) == 0);
                    default: out_stall = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_sample(input logic [RAW_W-1:0] word, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid    = 1'b1;
        raw_sample  = word;
        last_sample = is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        samples_in++;
        if (is_last)
            records_in++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_data  = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // drop valid, wait for every summary, then let the back stage go quiet
    task automatic drain();
        in_valid = 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int lo_tab[5] = '{0, 255, 255, 0, 200};
        int hi_tab[5] = '{255, 255, 0, 0, 255};
        int phase;
        int lo;
        int hi;
        int budget;
        int len;
        int style;
        int base;
        int amp;
        int height;
        int ppos;
        int lvl;
        int i;
        logic [RAW_W-1:0] fixed_word;
        logic [RAW_W-1:0] word;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_PED_FIRST;
        cfg_data    = '0;
        in_valid    = 1'b0;
        raw_sample  = '0;
        last_sample = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset window: lone sample with nothing above zero and no window hit
        send_sample(16'hFFFF, 1'b1);
        // ties keep the first maximum, upper bits ignored
        send_sample(16'h0FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hF000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8001, 1'b1);
        // flat window, zero variance
        send_sample(16'h0800, 1'b0);
        send_sample(16'h3800, 1'b0);
        send_sample(16'hC800, 1'b1);
        drain();

        write_reg(REG_PED_FIRST, 0);
        write_reg(REG_PED_LAST, 255);
        windows_set++;
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFE, 1'b1);
        drain();

        // first above last: empty window
        write_reg(REG_PED_FIRST, 9);
        write_reg(REG_PED_LAST, 3);
        windows_set++;
        send_sample(16'h1234, 1'b0);
        send_sample(16'h0FF0, 1'b0);
        send_sample(16'hF00F, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        drain();

        write_reg(REG_PED_FIRST, 0);
        write_reg(REG_PED_LAST, 0);
        windows_set++;
        send_sample(16'h0123, 1'b0);
        send_sample(16'h0456, 1'b1);
        drain();

        for (phase = 0; phase < 10; phase++)
        begin
            if (phase < 5)
            begin
                lo = lo_tab[phase];
                hi = hi_tab[phase];
            end
            else
            begin
                lo = $urandom_range(0, 120);
                hi = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(lo, lo + 100);
            end
            write_reg(REG_PED_FIRST, lo);
            write_reg(REG_PED_LAST, hi);
            windows_set++;

            budget = 45;
            while (budget > 0)
            begin
                // long records reach late windows and run past the sample limit
                if ((lo > 150) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 29) == 0))
                    len = $urandom_range(250, 300);
                else
                    len = $urandom_range(1, 40);
                style      = $urandom_range(0, 9);
                base       = $urandom_range(0, 4095);
                amp        = $urandom_range(0, 20);
                height     = $urandom_range(0, 4095);
                ppos       = $urandom_range(0, len - 1);
                fixed_word = RAW_W'($urandom);
                for (i = 0; i < len; i++)
                begin
                    if (style < 5)
                    begin
                        // pedestal with noise and one pulse
                        lvl = base + int'($urandom_range(0, 2 * amp)) - amp;
                        if (i == ppos)
                            lvl = lvl - height;
                        if (lvl < 0)
                            lvl = 0;
                        if (lvl > 4095)
                            lvl = 4095;
                        word = {4'($urandom), 12'(lvl)};
                    end
                    else if (style < 8)
                        word = RAW_W'($urandom);
                    else if (style == 8)
                        word = fixed_word;
                    else
                        word = {4'($urandom), ($urandom_range(0, 1) != 0) ? 12'h000 : 12'hFFF};
                    send_sample(word, i == len - 1);
                end
                budget = budget - len;
            end
            drain();
        end

        $display("%0d samples in %0d records over %0d pedestal windows, %0d summaries checked",
                 samples_in, records_in, windows_set, results_seen);
        $display("%0d mismatches, %0d summaries left pending", mismatches, waiting);
        if (mismatches == 0 && waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
